[src/erfw_pkg.sv]
package erfw_pkg;

    // Default fixed-point formats
    localparam int IN_FRAC_BITS_DEF  = 12;
    localparam int OUT_FRAC_BITS_DEF = 15;

    // Datapath widths
    localparam int X_W    = 16;   // input sample
    localparam int A_W    = 16;   // shape coefficient, unsigned Q0.16
    localparam int S_W    = 37;   // x^2 in Q32 below the large-argument bound
    localparam int D_W    = 38;   // ratio numerator / denominator
    localparam int Q_W    = 25;   // ratio quotient, Q24
    localparam int N_W    = 6;    // integer part of t*log2(e)
    localparam int F_W    = 32;   // fraction words
    localparam int P_W    = 33;   // series value, Q32 up to 1.0
    localparam int SPLIT  = 19;   // cut point for partial products
    localparam int L_W    = 27;   // log2(e) constant width

    localparam int SERIES_ORDER = 12;

    // Constants
    localparam logic [A_W-1:0] ALPHA_RESET    = 16'd9634;
    localparam logic [D_W-1:0] FOUR_BY_PI_Q32 = 38'd5468522205;
    localparam logic [L_W-1:0] LOG2E_Q26      = 27'd96817625;
    localparam logic [F_W-1:0] LN2_Q32        = 32'd2977044472;
    localparam logic [D_W-1:0] ONE_Q32        = 38'h01_0000_0000;
    localparam logic [D_W-1:0] BIG_ARG_Q32    = 38'h18_0000_0000;
    localparam logic [P_W-1:0] ONE_P          = 33'h1_0000_0000;

    // Payload carried through the divider cells
    typedef struct packed {
        logic           sign;
        logic           big;
        logic [S_W-1:0] s;
        logic [D_W-1:0] den;
        logic [D_W-1:0] rem;
        logic [Q_W-1:0] nb;
        logic [Q_W-1:0] q;
    } div_t;

    // Payload carried through the series cells
    typedef struct packed {
        logic           sign;
        logic           big;
        logic [N_W-1:0] n;
        logic [F_W-1:0] y;
        logic [P_W-1:0] p;
    } hrn_t;

endpackage

[src/erfw_div_cell.sv]
module erfw_div_cell
    import erfw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t din,
    output logic out_valid,
    output div_t dout
);

    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         fits;
    div_t         d_next;
    logic         valid_reg;
    div_t         d_reg;

    // One restoring division step: shift in the next numerator bit
    always_comb
    begin
        trial     = {din.rem, din.nb[Q_W-1]};
        diff      = trial - {1'b0, din.den};
        fits      = (trial >= {1'b0, din.den});
        d_next    = din;
        d_next.rem = fits ? diff[D_W-1:0] : trial[D_W-1:0];
        d_next.nb = {din.nb[Q_W-2:0], 1'b0};
        d_next.q  = {din.q[Q_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = d_reg;

endmodule

[src/erfw_horner_cell.sv]
module erfw_horner_cell
    import erfw_pkg::*;
#(
    parameter int K = SERIES_ORDER
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  hrn_t hin,
    output logic out_valid,
    output hrn_t hout
);

    // Reciprocal of K, low enough that the estimate is at most one short
    localparam logic [F_W-1:0] RECIP = 32'(64'hFFFF_FFFF / 64'(K));

    logic [2*F_W:0]   yp;
    logic [2*F_W-1:0] qp;
    logic [F_W+3:0]   kq;
    logic [F_W+3:0]   rem;
    logic [F_W-1:0]   q;
    hrn_t             h_next;

    logic             v1_valid_reg;
    hrn_t             h1_reg;
    logic [F_W-1:0]   v1_reg;
    logic             v2_valid_reg;
    hrn_t             h2_reg;
    logic [F_W-1:0]   v2_reg;
    logic [F_W-1:0]   qe2_reg;
    logic             v3_valid_reg;
    hrn_t             h3_reg;

    // Stage 1: y * p
    assign yp = (2*F_W+1)'(hin.y) * (2*F_W+1)'(hin.p);

    // Stage 2: quotient estimate by reciprocal multiply
    assign qp = (2*F_W)'(v1_reg) * (2*F_W)'(RECIP);

    // Stage 3: correct the estimate, then p = 1 - v/K
    always_comb
    begin
        kq      = (F_W+4)'(qe2_reg) * (F_W+4)'(K);
        rem     = (F_W+4)'(v2_reg) - kq;
        q       = qe2_reg + F_W'(rem >= (F_W+4)'(K));
        h_next  = h2_reg;
        h_next.p = ONE_P - {1'b0, q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
            v3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_valid_reg <= in_valid;
            v2_valid_reg <= v1_valid_reg;
            v3_valid_reg <= v2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg  <= hin;
            v1_reg  <= yp[2*F_W-1:F_W];
            h2_reg  <= h1_reg;
            v2_reg  <= v1_reg;
            qe2_reg <= qp[2*F_W-1:F_W];
            h3_reg  <= h_next;
        end
    end

    assign out_valid = v3_valid_reg;
    assign hout      = h3_reg;

endmodule

[src/erfw_sqrt_cell.sv]
module erfw_sqrt_cell
    import erfw_pkg::*;
#(
    parameter int RAD_W   = 2 * OUT_FRAC_BITS_DEF + 1,
    parameter int BIT_POS = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic             in_sign,
    input  logic [RAD_W-1:0] in_v,
    input  logic [RAD_W-1:0] in_r,
    output logic             out_valid,
    output logic             out_sign,
    output logic [RAD_W-1:0] out_v,
    output logic [RAD_W-1:0] out_r
);

    localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << BIT_POS;

    logic [RAD_W:0]   sum;
    logic [RAD_W:0]   rest;
    logic [RAD_W-1:0] r_half;
    logic             fits;
    logic [RAD_W-1:0] v_next;
    logic [RAD_W-1:0] r_next;

    logic             valid_reg;
    logic             sign_reg;
    logic [RAD_W-1:0] v_reg;
    logic [RAD_W-1:0] r_reg;

    // One digit of the bitwise square root
    always_comb
    begin
        sum    = {1'b0, in_r} + BIT;
        fits   = ({1'b0, in_v} >= sum);
        rest   = {1'b0, in_v} - sum;
        r_half = in_r >> 1;
        v_next = fits ? rest[RAD_W-1:0] : in_v;
        r_next = fits ? RAD_W'({1'b0, r_half} + BIT) : r_half;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= in_sign;
            v_reg    <= v_next;
            r_reg    <= r_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sign  = sign_reg;
    assign out_v     = v_reg;
    assign out_r     = r_reg;

endmodule

[src/erf_rational_exp_sqrt_approx_core.sv]
// Throughput: one transfer per cycle on both sides while no stall holds them; every stage is a register.
// Depth is set by the 25-cell divider, 12 series cells of 3 stages and the root cells.
// An output register and a one-entry skid buffer let the pipe advance while a result is stalled, until the skid fills.
// Reset (rst_n low, asynchronous) empties the pipe and loads the coefficient with 0.147.
module erf_rational_exp_sqrt_approx_core
    import erfw_pkg::*;
#(
    parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [X_W-1:0] x_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [X_W-1:0] erf_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [A_W-1:0]        alpha_coeff_q16
);

    localparam int SHIFT_IN  = 32 - 2 * IN_FRAC_BITS;
    localparam int SHIFT_OUT = 2 * OUT_FRAC_BITS - 32;
    localparam int RAD_W     = P_W + SHIFT_OUT;
    localparam int N_SQ      = (RAD_W + 1) / 2;
    localparam int M_W       = N_SQ + 1;
    localparam int LIM_I     = (OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS) - 1;
    localparam logic [M_W-1:0] LIM = M_W'(LIM_I);
    localparam int SQ_W      = 2 * (X_W + 1);

    // Coefficient register
    logic [A_W-1:0] alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_valid)
        begin
            alpha_reg <= alpha_coeff_q16;
        end
    end

    assign cfg_ready = 1'b1;

    // Pipe advance: held only while the output buffer is full
    logic adv;
    logic skid_full_reg;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // Stage 1: magnitude squared
    logic [X_W:0]    mag;
    logic            p1_valid_reg;
    logic            p1_sign_reg;
    logic [SQ_W-1:0] p1_sq_reg;

    assign mag = x_value[X_W-1] ? ((X_W+1)'(1 << X_W) - {1'b0, x_value}) : {1'b0, x_value};

    // Stage 2: scale to Q32, large-argument test, a*s partial products
    logic [63:0]         s_wide;
    logic [S_W-1:0]      s_small;
    logic                p2_valid_reg;
    logic                p2_sign_reg;
    logic                p2_big_reg;
    logic [S_W-1:0]      p2_s_reg;
    logic [A_W+SPLIT-1:0] p2_lo_reg;
    logic [A_W+S_W-SPLIT-1:0] p2_hi_reg;

    generate
        if (SHIFT_IN >= 0)
        begin : g_in_up
            assign s_wide = 64'(p1_sq_reg) << SHIFT_IN;
        end
        else
        begin : g_in_down
            assign s_wide = 64'(p1_sq_reg) >> (-SHIFT_IN);
        end
    endgenerate

    assign s_small = s_wide[S_W-1:0];

    // Stage 3: a*s summed, Q32
    logic [A_W+S_W-1:0] as_sum;
    logic               p3_valid_reg;
    logic               p3_sign_reg;
    logic               p3_big_reg;
    logic [S_W-1:0]     p3_s_reg;
    logic [S_W-1:0]     p3_as_reg;

    assign as_sum = (A_W+S_W)'(p2_lo_reg) + ((A_W+S_W)'(p2_hi_reg) << SPLIT);

    // Stage 4: ratio numerator and denominator, divider setup
    logic [D_W-1:0] num;
    div_t           d0;
    logic           p4_valid_reg;
    div_t           p4_reg;

    always_comb
    begin
        num    = FOUR_BY_PI_Q32 + D_W'(p3_as_reg);
        d0.sign = p3_sign_reg;
        d0.big = p3_big_reg;
        d0.s   = p3_s_reg;
        d0.den = ONE_Q32 + D_W'(p3_as_reg);
        d0.rem = num >> 1;
        d0.nb  = {num[0], {(Q_W-1){1'b0}}};
        d0.q   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sign_reg <= x_value[X_W-1];
            p1_sq_reg   <= SQ_W'(mag) * SQ_W'(mag);
            p2_sign_reg <= p1_sign_reg;
            p2_big_reg  <= (s_wide >= 64'(BIG_ARG_Q32));
            p2_s_reg    <= s_small;
            p2_lo_reg   <= (A_W+SPLIT)'(alpha_reg) * (A_W+SPLIT)'(s_small[SPLIT-1:0]);
            p2_hi_reg   <= (A_W+S_W-SPLIT)'(alpha_reg)
                           * (A_W+S_W-SPLIT)'(s_small[S_W-1:SPLIT]);
            p3_sign_reg <= p2_sign_reg;
            p3_big_reg  <= p2_big_reg;
            p3_s_reg    <= p2_s_reg;
            p3_as_reg   <= as_sum[A_W+S_W-1:A_W];
            p4_reg      <= d0;
        end
    end

    // Divider chain: one quotient bit per cell
    logic div_v [0:Q_W];
    div_t div_d [0:Q_W];

    assign div_v[0] = p4_valid_reg;
    assign div_d[0] = p4_reg;

    generate
        for (genvar i = 0; i < Q_W; i++)
        begin : g_div
            erfw_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (div_v[i]),
                .din       (div_d[i]),
                .out_valid (div_v[i+1]),
                .dout      (div_d[i+1])
            );
        end
    endgenerate

    // Stage 5: r*s partial products
    logic                     p5_valid_reg;
    logic                     p5_sign_reg;
    logic                     p5_big_reg;
    logic [Q_W+SPLIT-1:0]     p5_lo_reg;
    logic [Q_W+S_W-SPLIT-1:0] p5_hi_reg;

    // Stage 6: t = r*s in Q32, second large-argument test
    logic [Q_W+S_W-1:0] rs_sum;
    logic [D_W-1:0]     t_full;
    logic               p6_valid_reg;
    logic               p6_sign_reg;
    logic               p6_big_reg;
    logic [S_W-1:0]     p6_t_reg;

    assign rs_sum = (Q_W+S_W)'(p5_lo_reg) + ((Q_W+S_W)'(p5_hi_reg) << SPLIT);
    assign t_full = rs_sum[Q_W+S_W-1:24];

    // Stage 7: t*log2(e) partial products
    logic                     p7_valid_reg;
    logic                     p7_sign_reg;
    logic                     p7_big_reg;
    logic [L_W+SPLIT-1:0]     p7_lo_reg;
    logic [L_W+S_W-SPLIT-1:0] p7_hi_reg;

    // Stage 8: split into integer and fraction of the power of two
    logic [63:0]    u_sum;
    logic           p8_valid_reg;
    logic           p8_sign_reg;
    logic           p8_big_reg;
    logic [N_W-1:0] p8_n_reg;
    logic [F_W-1:0] p8_f_reg;

    assign u_sum = 64'(p7_lo_reg) + (64'(p7_hi_reg) << SPLIT);

    // Stage 9: y = f*ln2, series setup
    logic [2*F_W-1:0] y_prod;
    hrn_t             h0;
    logic             p9_valid_reg;
    hrn_t             p9_reg;

    always_comb
    begin
        y_prod  = (2*F_W)'(p8_f_reg) * (2*F_W)'(LN2_Q32);
        h0.sign = p8_sign_reg;
        h0.big  = p8_big_reg;
        h0.n    = p8_n_reg;
        h0.y    = y_prod[2*F_W-1:F_W];
        h0.p    = ONE_P;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
            p8_valid_reg <= 1'b0;
            p9_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p5_valid_reg <= div_v[Q_W];
            p6_valid_reg <= p5_valid_reg;
            p7_valid_reg <= p6_valid_reg;
            p8_valid_reg <= p7_valid_reg;
            p9_valid_reg <= p8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_sign_reg <= div_d[Q_W].sign;
            p5_big_reg  <= div_d[Q_W].big;
            p5_lo_reg   <= (Q_W+SPLIT)'(div_d[Q_W].q)
                           * (Q_W+SPLIT)'(div_d[Q_W].s[SPLIT-1:0]);
            p5_hi_reg   <= (Q_W+S_W-SPLIT)'(div_d[Q_W].q)
                           * (Q_W+S_W-SPLIT)'(div_d[Q_W].s[S_W-1:SPLIT]);
            p6_sign_reg <= p5_sign_reg;
            p6_big_reg  <= p5_big_reg || (t_full >= BIG_ARG_Q32);
            p6_t_reg    <= t_full[S_W-1:0];
            p7_sign_reg <= p6_sign_reg;
            p7_big_reg  <= p6_big_reg;
            p7_lo_reg   <= (L_W+SPLIT)'(p6_t_reg[SPLIT-1:0]) * (L_W+SPLIT)'(LOG2E_Q26);
            p7_hi_reg   <= (L_W+S_W-SPLIT)'(p6_t_reg[S_W-1:SPLIT])
                           * (L_W+S_W-SPLIT)'(LOG2E_Q26);
            p8_sign_reg <= p7_sign_reg;
            p8_big_reg  <= p7_big_reg;
            p8_n_reg    <= u_sum[F_W+26+N_W-1:F_W+26];
            p8_f_reg    <= u_sum[F_W+26-1:26];
            p9_reg      <= h0;
        end
    end

    // Series chain: exp(-y) by Horner steps, highest order first
    logic hrn_v [0:SERIES_ORDER];
    hrn_t hrn_d [0:SERIES_ORDER];

    assign hrn_v[0] = p9_valid_reg;
    assign hrn_d[0] = p9_reg;

    generate
        for (genvar i = 0; i < SERIES_ORDER; i++)
        begin : g_hrn
            erfw_horner_cell #(
                .K (SERIES_ORDER - i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (hrn_v[i]),
                .hin       (hrn_d[i]),
                .out_valid (hrn_v[i+1]),
                .hout      (hrn_d[i+1])
            );
        end
    endgenerate

    // Stage 10: w = 1 - exp(-t), scaled for the root
    logic [P_W-1:0]   p_shift;
    logic [P_W-1:0]   w;
    logic [RAD_W-1:0] rad;
    logic             p10_valid_reg;
    logic             p10_sign_reg;
    logic [RAD_W-1:0] p10_rad_reg;

    assign p_shift = hrn_d[SERIES_ORDER].p >> hrn_d[SERIES_ORDER].n;
    assign w       = hrn_d[SERIES_ORDER].big ? ONE_P : (ONE_P - p_shift);

    generate
        if (SHIFT_OUT >= 0)
        begin : g_out_up
            assign rad = RAD_W'(w) << SHIFT_OUT;
        end
        else
        begin : g_out_down
            assign rad = RAD_W'(w >> (-SHIFT_OUT));
        end
    endgenerate

    // Root chain: one result bit per cell
    logic             sq_v [0:N_SQ];
    logic             sq_s [0:N_SQ];
    logic [RAD_W-1:0] sq_rv [0:N_SQ];
    logic [RAD_W-1:0] sq_rr [0:N_SQ];

    assign sq_v[0]  = p10_valid_reg;
    assign sq_s[0]  = p10_sign_reg;
    assign sq_rv[0] = p10_rad_reg;
    assign sq_rr[0] = '0;

    generate
        for (genvar j = 0; j < N_SQ; j++)
        begin : g_sq
            erfw_sqrt_cell #(
                .RAD_W   (RAD_W),
                .BIT_POS (2 * (N_SQ - 1 - j))
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (sq_v[j]),
                .in_sign   (sq_s[j]),
                .in_v      (sq_rv[j]),
                .in_r      (sq_rr[j]),
                .out_valid (sq_v[j+1]),
                .out_sign  (sq_s[j+1]),
                .out_v     (sq_rv[j+1]),
                .out_r     (sq_rr[j+1])
            );
        end
    endgenerate

    // Stage 11: round to nearest, ties down
    logic           p11_valid_reg;
    logic           p11_sign_reg;
    logic [M_W-1:0] p11_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p10_valid_reg <= 1'b0;
            p11_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p10_valid_reg <= hrn_v[SERIES_ORDER];
            p11_valid_reg <= sq_v[N_SQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p10_sign_reg <= hrn_d[SERIES_ORDER].sign;
            p10_rad_reg  <= rad;
            p11_sign_reg <= sq_s[N_SQ];
            p11_m_reg    <= sq_rr[N_SQ][M_W-1:0]
                            + M_W'(sq_rv[N_SQ] > sq_rr[N_SQ]);
        end
    end

    // Saturate and apply sign
    logic [M_W-1:0] m_sat;
    logic [X_W-1:0] m_mag;
    logic [X_W-1:0] end_data;
    logic           end_valid;

    assign m_sat     = (p11_m_reg > LIM) ? LIM : p11_m_reg;
    assign m_mag     = X_W'(m_sat);
    assign end_data  = p11_sign_reg ? (X_W'(0) - m_mag) : m_mag;
    assign end_valid = adv && p11_valid_reg;

    // Output register with a one-entry skid buffer
    logic           out_free;
    logic           out_valid_reg;
    logic [X_W-1:0] out_data_reg;
    logic [X_W-1:0] skid_data_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= skid_full_reg || end_valid;
            skid_full_reg <= 1'b0;
        end
        else if (end_valid)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_full_reg ? skid_data_reg : end_data;
        end
        else if (end_valid)
        begin
            skid_data_reg <= end_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign erf_value = signed'(out_data_reg);

endmodule

[tb/tb_erf_rational_exp_sqrt_approx_core.sv]
module tb_erf_rational_exp_sqrt_approx_core;
    import erfw_pkg::*;

    localparam int RUN_LIMIT   = 500000;
    localparam int PIPE_FLUSH  = 120;
    localparam int PHASE_ITEMS = 200;

    // Expected erf codes, with a private copy of the shape coefficient
    class erf_scoreboard;
        logic [15:0]     erf_expected[$];
        logic [A_W-1:0]  alpha;
        int              mismatches;
        int              checked;

        function new();
            alpha      = ALPHA_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        // 1 - exp(-t), t in Q32 below 24.0
        function logic [63:0] one_minus_exp(logic [63:0] t);
            logic [63:0] u, n, f, y, p;
            u = (t * 64'd96817625) >> 26;
            n = u >> 32;
            f = u & 64'hFFFF_FFFF;
            y = (f * 64'd2977044472) >> 32;
            p = 64'h1_0000_0000;
            for (int k = SERIES_ORDER; k >= 1; k--)
                p = 64'h1_0000_0000 - (((y * p) >> 32) / k);
            if (n > 63)
                n = 63;
            return 64'h1_0000_0000 - (p >> n);
        endfunction

        // integer square root, rounded to nearest, ties down
        function logic [63:0] root_nearest(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            if (v > r)
                r = r + 1;
            return r;
        endfunction

        function logic [15:0] erf_of(logic [15:0] x);
            logic        neg;
            logic [63:0] mag, s, as_q, r, t, w, m;
            neg = x[15];
            mag = neg ? (64'h10000 - x) : x;
            s   = (mag * mag) << (32 - 2 * IN_FRAC_BITS_DEF);
            if (s >= 64'h18_0000_0000)
                w = 64'h1_0000_0000;
            else
            begin
                as_q = (alpha * s) >> 16;
                r    = ((64'd5468522205 + as_q) << 24) / (64'h1_0000_0000 + as_q);
                t    = (r * s) >> 24;
                w    = (t >= 64'h18_0000_0000) ? 64'h1_0000_0000 : one_minus_exp(t);
            end
            m = root_nearest(w >> (32 - 2 * OUT_FRAC_BITS_DEF));
            if (m > 32767)
                m = 32767;
            return neg ? (16'd0 - m[15:0]) : m[15:0];
        endfunction

        function void note_input(logic [15:0] x);
            erf_expected.push_back(erf_of(x));
        endfunction

        function void check_result(logic [15:0] got, longint unsigned now);
            logic [15:0] want;
            checked++;
            if (erf_expected.size() == 0)
            begin
                $display("%0t: erf_value %h arrived with nothing expected", now, got);
                mismatches++;
                return;
            end
            want = erf_expected.pop_front();
            if (got !== want)
            begin
                $display("%0t: erf_value expected %h actual %h", now, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic signed [X_W-1:0] x_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [X_W-1:0] erf_value;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [A_W-1:0]        alpha_coeff_q16 = '0;

    erf_scoreboard sb = new();
    bit            quiet = 1'b0;
    int            cycles = 0;
    int            sent = 0;

    erf_rational_exp_sqrt_approx_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .x_value         (x_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .erf_value       (erf_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .alpha_coeff_q16 (alpha_coeff_q16)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall bursts at random
    always @(posedge clk)
    begin : stall_gen
        int hold;
        if (quiet)
        begin
            hold = 0;
            out_stall <= 1'b0;
        end
        else if (hold > 0)
            hold = hold - 1;
        else if ($urandom_range(0, 5) == 0)
        begin
            hold = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result transfers: values sampled mid-cycle hold through the next edge
    always @(negedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(erf_value, $time);

    task automatic send_x(logic [15:0] x);
        bit acc;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= x;
        do
        begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
        end
        while (!acc);
        sb.note_input(x);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.erf_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    task automatic write_alpha(logic [A_W-1:0] a);
        bit acc;
        cfg_valid       <= 1'b1;
        alpha_coeff_q16 <= a;
        do
        begin
            @(negedge clk);
            acc = cfg_ready;
            @(posedge clk);
        end
        while (!acc);
        cfg_valid <= 1'b0;
        sb.alpha = a;
    endtask

    // mostly the interesting band below |x| = 5, some full-range samples
    function automatic logic [15:0] pick_x();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 2047)) ^ {16{1'($urandom)}};
            default: return 16'($urandom_range(0, 20480)) ^ {16{1'($urandom)}};
        endcase
    endfunction

    logic [15:0] directed_x[] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                  16'h1000, 16'hF000, 16'h2000, 16'h0800, 16'h0010,
                                  16'h4E62, 16'h4E63, 16'hB19D, 16'h3000, 16'h5555,
                                  16'hAAAA, 16'h0400, 16'hC000};
    logic [A_W-1:0] alpha_set[] = '{16'd0, 16'd65535, 16'd9634, 16'd0, 16'd65535};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples under the reset coefficient
        foreach (directed_x[i])
            send_x(directed_x[i]);
        drain();

        for (int ph = 0; ph <= alpha_set.size(); ph++)
        begin
            if (ph < alpha_set.size())
                write_alpha(alpha_set[ph]);
            else
            begin
                write_alpha(A_W'($urandom_range(0, 65535)));
                quiet = 1'b1;
            end
            send_x(16'h0000);
            send_x(16'h8000);
            send_x(16'h7FFF);
            for (int i = 0; i < PHASE_ITEMS - 30; i++)
                send_x(pick_x());
            drain();
        end

        $display("covered %0d samples, %0d results checked, over %0d coefficient settings",
                 sent, sb.checked, alpha_set.size() + 2);
        $display("including 0, 65535 and the reset value, with random stalls on both sides");
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
src/erfw_pkg.sv
src/erfw_div_cell.sv
src/erfw_horner_cell.sv
src/erfw_sqrt_cell.sv
src/erf_rational_exp_sqrt_approx_core.sv
tb/tb_erf_rational_exp_sqrt_approx_core.sv
